// ===== rtl/assert_macros.svh =====
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off while reset is high
`define S2H_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, off while reset is high
`define S2H_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

// next-cycle implication, also checked through reset
`define S2H_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/s2hkbd_pkg.sv =====
// types, constants and lookup tables of the boot keyboard report keeper
package s2hkbd_pkg;

  localparam int KEY_SLOTS = 6;
  localparam int SLOT_FIELDS = 6;
  localparam int SHOWN_SLOTS = (KEY_SLOTS < SLOT_FIELDS) ? KEY_SLOTS : SLOT_FIELDS;
  localparam int CNT_W = $clog2(KEY_SLOTS + 1);
  localparam int SLOT_IW = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1;

  localparam int ROM_END = 'h70;
  localparam int MOD_FIRST = 'h60;
  localparam int MOD_END = 'h68;
  localparam int CAPS_CODE = 'h62;
  localparam logic [7:0] TICK_STEP = 8'd5;
  localparam logic [7:0] TICK_LIMIT = 8'd4;

  localparam logic [7:0] USAGE_ROM [ROM_END] = '{
    8'h35,8'h1E,8'h1F,8'h20,8'h21,8'h22,8'h23,8'h24,
    8'h25,8'h26,8'h27,8'h2D,8'h2E,8'h44,8'h00,8'h62,
    8'h14,8'h1A,8'h08,8'h15,8'h17,8'h1C,8'h18,8'h0C,
    8'h12,8'h13,8'h2F,8'h30,8'h00,8'h59,8'h5A,8'h5B,
    8'h04,8'h16,8'h07,8'h09,8'h0A,8'h0B,8'h0D,8'h0E,
    8'h0F,8'h33,8'h34,8'h32,8'h00,8'h5C,8'h5D,8'h5E,
    8'h64,8'h1D,8'h1B,8'h06,8'h19,8'h05,8'h11,8'h10,
    8'h36,8'h37,8'h38,8'h00,8'h63,8'h5F,8'h60,8'h61,
    8'h2C,8'h2A,8'h2B,8'h58,8'h28,8'h29,8'h4C,8'h00,
    8'h00,8'h00,8'h56,8'h00,8'h52,8'h51,8'h4F,8'h50,
    8'h3A,8'h3B,8'h3C,8'h3D,8'h3E,8'h3F,8'h40,8'h41,
    8'h42,8'h43,8'h4A,8'h4D,8'h54,8'h55,8'h57,8'h45,
    8'h00,8'h00,8'h39,8'h00,8'h00,8'h00,8'h00,8'h00,
    8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00
  };

  localparam logic [7:0] MOD_ROM [8] = '{
    8'h02, 8'h20, 8'h00, 8'h01, 8'h04, 8'h40, 8'h08, 8'h80
  };

  localparam logic [7:0] CAPS_USAGE = USAGE_ROM[CAPS_CODE];
  localparam logic [7:0] CAPS_MASK = MOD_ROM[CAPS_CODE - MOD_FIRST];

  typedef struct packed {
    logic       cmd;
    logic [6:0] key_index;
    logic       key_up;
  } item_t;

  typedef struct packed {
    logic [7:0] modifier_bits;
    logic [7:0] slot_one;
    logic [7:0] slot_two;
    logic [7:0] slot_three;
    logic [7:0] slot_four;
    logic [7:0] slot_five;
    logic [7:0] slot_six;
  } report_t;

  typedef enum logic [1:0] {
    OP_PRESS,
    OP_RELEASE,
    OP_TICK
  } op_t;

  // item after decode, as held in the queue
  typedef struct packed {
    op_t        op;
    logic [7:0] usage;
    logic [7:0] mask;
    logic       is_caps;
  } cls_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic logic [7:0] code_usage(logic [6:0] code);
    logic [7:0] u;
    u = 8'h00;
    if (code < 7'(ROM_END)) begin
      u = USAGE_ROM[code];
    end
    return u;
  endfunction

  function automatic logic [7:0] code_modifier(logic [6:0] code);
    logic [7:0] m;
    m = 8'h00;
    if (code >= 7'(MOD_FIRST) && code < 7'(MOD_END)) begin
      m = MOD_ROM[code[2:0]];
    end
    return m;
  endfunction

endpackage

// ===== rtl/scancode_to_hid_keyboard_report_top.sv =====
// top level of the boot keyboard report keeper
// One command (key event or timer tick) is taken per clock while busy is low. A command is
// decoded in the front end, passes a two-entry queue and is executed by the report engine,
// which takes one queued command every cycle; after the queue entry and report_valid registers,
// a key event's report strobes report_valid for one cycle only, since the receiver cannot stall.
// Ticks that only count down the idle timer give no report. busy is high only while the queue is
// full. No clearing pass follows reset: all state but the report and queue entries resets at once.
module scancode_to_hid_keyboard_report_top (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  s2hkbd_pkg::item_t   item,
  output logic                busy,
  input  logic                idle_rate_we,
  input  logic [7:0]          idle_rate,
  output logic                report_valid,
  output s2hkbd_pkg::report_t report
);
  import s2hkbd_pkg::*;

  q_stat_t stat;
  logic    push;
  logic    pop;
  cls_t    cls_in;
  cls_t    cls_out;

  s2hkbd_front u_front (
    .start (start),
    .item  (item),
    .stat  (stat),
    .busy  (busy),
    .push  (push),
    .cls   (cls_in)
  );

  s2hkbd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (cls_in),
    .pop       (pop),
    .pop_data  (cls_out),
    .stat      (stat)
  );

  s2hkbd_back u_back (
    .clk          (clk),
    .rst          (rst),
    .idle_rate_we (idle_rate_we),
    .idle_rate_in (idle_rate),
    .stat         (stat),
    .cls          (cls_out),
    .pop          (pop),
    .report_valid (report_valid),
    .report       (report)
  );

endmodule

// ===== rtl/s2hkbd_front.sv =====
// front end: takes commands and decodes key codes into usages and modifier masks
module s2hkbd_front (
  input  logic              start,
  input  s2hkbd_pkg::item_t item,
  input  s2hkbd_pkg::q_stat_t stat,
  output logic              busy,
  output logic              push,
  output s2hkbd_pkg::cls_t  cls
);
  import s2hkbd_pkg::*;

  assign busy = stat.full;
  assign push = start && !stat.full;

  always_comb begin
    cls.usage = code_usage(item.key_index);
    cls.mask = code_modifier(item.key_index);
    cls.is_caps = (item.key_index == 7'(CAPS_CODE));
    priority if (item.cmd) begin
      cls.op = OP_TICK;
    end else if (item.key_up) begin
      cls.op = OP_RELEASE;
    end else begin
      cls.op = OP_PRESS;
    end
  end

endmodule

// ===== rtl/s2hkbd_queue.sv =====
// two-entry queue between the decoder and the report engine
module s2hkbd_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  s2hkbd_pkg::cls_t    push_data,
  input  logic                pop,
  output s2hkbd_pkg::cls_t    pop_data,
  output s2hkbd_pkg::q_stat_t stat
);
  import s2hkbd_pkg::*;

  cls_t       entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;

  assign stat.full = (count == 2'd2);
  assign stat.empty = (count == 2'd0);
  assign do_push = push && !stat.full;
  assign do_pop = pop && !stat.empty;
  assign pop_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      unique case ({do_push, do_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== rtl/s2hkbd_back.sv =====
// report engine: updates modifier byte, key slots and idle timer, emits reports
module s2hkbd_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                idle_rate_we,
  input  logic [7:0]          idle_rate_in,
  input  s2hkbd_pkg::q_stat_t stat,
  input  s2hkbd_pkg::cls_t    cls,
  output logic                pop,
  output logic                report_valid,
  output s2hkbd_pkg::report_t report
);
  import s2hkbd_pkg::*;

  logic [7:0]       idle_rate;
  logic [7:0]       mod_reg;
  logic [7:0]       slots [KEY_SLOTS];
  logic [CNT_W-1:0] slot_count;
  logic             caps_pending;
  logic [7:0]       idle_count;

  logic [7:0]       mod_next;
  logic [7:0]       slots_next [KEY_SLOTS];
  logic [CNT_W-1:0] slot_count_next;
  logic             caps_next;
  logic [7:0]       idle_next;
  logic             emit;
  logic             rel_en;
  logic [7:0]       rel_usage;
  logic             found;
  logic [SLOT_IW-1:0] first;
  logic [7:0]       shown [SLOT_FIELDS];
  report_t          report_next;

  // the engine never stalls, so it drains the queue every cycle
  assign pop = !stat.empty;

  always_comb begin
    mod_next = mod_reg;
    slots_next = slots;
    slot_count_next = slot_count;
    caps_next = caps_pending;
    idle_next = idle_count;
    emit = 1'b0;
    rel_en = 1'b0;
    rel_usage = cls.usage;
    found = 1'b0;
    first = '0;
    if (pop) begin
      unique case (cls.op)
        OP_PRESS: begin
          emit = 1'b1;
          if (cls.usage != 8'h00 && slot_count < CNT_W'(KEY_SLOTS)) begin
            slots_next[slot_count[SLOT_IW-1:0]] = cls.usage;
            slot_count_next = slot_count + CNT_W'(1);
            if (cls.is_caps) begin
              caps_next = 1'b1;
            end
          end
          mod_next = mod_reg | cls.mask;
        end
        OP_RELEASE: begin
          emit = 1'b1;
          rel_en = 1'b1;
          mod_next = mod_reg & ~cls.mask;
        end
        OP_TICK: begin
          if (idle_rate != 8'h00) begin
            if (idle_count > TICK_LIMIT) begin
              idle_next = idle_count - TICK_STEP;
            end else begin
              idle_next = idle_rate;
              emit = 1'b1;
              if (caps_pending) begin
                // automatic caps lock release
                rel_en = 1'b1;
                rel_usage = CAPS_USAGE;
                caps_next = 1'b0;
                mod_next = mod_reg & ~CAPS_MASK;
              end
            end
          end
        end
        default: begin
          emit = 1'b0;
        end
      endcase
    end

    // first occupied slot that holds the released usage
    for (int i = 0; i < KEY_SLOTS; i++) begin
      if (!found && rel_usage != 8'h00 && CNT_W'(i) < slot_count && slots[i] == rel_usage) begin
        found = 1'b1;
        first = SLOT_IW'(i);
      end
    end
    if (rel_en && found) begin
      for (int j = 0; j < KEY_SLOTS - 1; j++) begin
        if (SLOT_IW'(j) >= first) begin
          slots_next[j] = slots[j + 1];
        end
      end
      slots_next[KEY_SLOTS - 1] = 8'h00;
      slot_count_next = slot_count - CNT_W'(1);
    end
  end

  always_comb begin
    for (int k = 0; k < SLOT_FIELDS; k++) begin
      shown[k] = 8'h00;
    end
    for (int k = 0; k < SHOWN_SLOTS; k++) begin
      shown[k] = slots_next[k];
    end
    report_next.modifier_bits = mod_next;
    report_next.slot_one = shown[0];
    report_next.slot_two = shown[1];
    report_next.slot_three = shown[2];
    report_next.slot_four = shown[3];
    report_next.slot_five = shown[4];
    report_next.slot_six = shown[5];
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      report <= report_next;
    end
    if (rst) begin
      idle_rate <= 8'h00;
      mod_reg <= 8'h00;
      for (int i = 0; i < KEY_SLOTS; i++) begin
        slots[i] <= 8'h00;
      end
      slot_count <= '0;
      caps_pending <= 1'b0;
      idle_count <= 8'h00;
      report_valid <= 1'b0;
    end else begin
      if (idle_rate_we) begin
        idle_rate <= idle_rate_in;
      end
      mod_reg <= mod_next;
      slots <= slots_next;
      slot_count <= slot_count_next;
      caps_pending <= caps_next;
      idle_count <= idle_next;
      report_valid <= emit;
    end
  end

endmodule

// ===== rtl/s2hkbd_checker.sv =====
// port-level checks of the report keeper, bound to the top level
`include "assert_macros.svh"

module s2hkbd_checker (
  input logic                clk,
  input logic                rst,
  input logic                start,
  input s2hkbd_pkg::item_t   item,
  input logic                busy,
  input logic                report_valid,
  input s2hkbd_pkg::report_t report
);
  import s2hkbd_pkg::*;

  logic key_xfer;
  logic any_xfer;
  logic slots_packed;

  assign any_xfer = start && !busy;
  assign key_xfer = any_xfer && !item.cmd;
  // an empty slot is never followed by an occupied one
  assign slots_packed =
    (report.slot_one != 8'h00 || report.slot_two == 8'h00) &&
    (report.slot_two != 8'h00 || report.slot_three == 8'h00) &&
    (report.slot_three != 8'h00 || report.slot_four == 8'h00) &&
    (report.slot_four != 8'h00 || report.slot_five == 8'h00) &&
    (report.slot_five != 8'h00 || report.slot_six == 8'h00);

  `S2H_ASSERT_NEXT_ALWAYS(a_quiet_after_reset, clk, rst, !report_valid)
  `S2H_ASSERT_NEXT(a_key_gives_report, clk, rst, key_xfer, ##1 report_valid)
  `S2H_ASSERT_IMP(a_report_has_cause, clk, rst, report_valid, $past(any_xfer, 2))
  `S2H_ASSERT_IMP(a_slots_packed, clk, rst, report_valid, slots_packed)

endmodule

bind scancode_to_hid_keyboard_report_top s2hkbd_checker u_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .item         (item),
  .busy         (busy),
  .report_valid (report_valid),
  .report       (report)
);
